// ===== sv/memory_map_run_coalescer_macros.svh =====
// Assertion macros shared by the memory map run coalescer modules.
`ifndef MEMORY_MAP_RUN_COALESCER_MACROS_SVH
`define MEMORY_MAP_RUN_COALESCER_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define MMRC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define MMRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mmrc_pkg.sv =====
// Types and constants of the memory map run coalescer.
`default_nettype none

package mmrc_pkg;

    localparam int TYPE_W     = 4;
    localparam int START_W    = 52;
    localparam int PAGES_W    = 40;
    localparam int ATTR_W     = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int MASK_W     = 16;
    localparam int DESC_W     = TYPE_W + START_W + PAGES_W + ATTR_W;

    localparam logic [MASK_W-1:0] MASK_RESET = 16'd24;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index codes (paddr[2])
    localparam logic REG_IDX_MERGE_MASK = 1'b0;

    localparam logic [PAGES_W-1:0] PAGES_MAX = {PAGES_W{1'b1}};

    // First member is the most significant: dtype lands in the lowest bits.
    typedef struct packed {
        logic [ATTR_W-1:0]  attr;
        logic [PAGES_W-1:0] pages;
        logic [START_W-1:0] start;
        logic [TYPE_W-1:0]  dtype;
    } desc_t;

    typedef struct packed {
        logic  last;
        desc_t desc;
    } entry_t;

    // Up to two result words per accepted descriptor, slot a first.
    typedef struct packed {
        logic   a_valid;
        logic   b_valid;
        entry_t a;
        entry_t b;
    } qpush_t;

endpackage

`default_nettype wire

// ===== sv/mmrc_cfg.sv =====
// APB register file holding the mergeable type mask.
`default_nettype none

module mmrc_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mmrc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [mmrc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [mmrc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic      [mmrc_pkg::MASK_W-1:0]      type_mask
);
    import mmrc_pkg::*;

    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic              reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb begin
        mask_next = mask_reg;
        if (wr_en && reg_idx == REG_IDX_MERGE_MASK) begin
            mask_next = pwdata[MASK_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= MASK_RESET;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_IDX_MERGE_MASK: prdata = {{(APB_DATA_W-MASK_W){1'b0}}, mask_reg};
            default:            prdata = '0;
        endcase
    end

    assign type_mask = mask_reg;

endmodule

`default_nettype wire

// ===== sv/mmrc_merge.sv =====
// Input register, pending descriptor and merge decision.
`default_nettype none

`include "memory_map_run_coalescer_macros.svh"

module mmrc_merge (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [mmrc_pkg::DESC_W-1:0]  s_tdata,
    input  wire logic                         s_tlast,
    input  wire logic [mmrc_pkg::MASK_W-1:0]  type_mask,
    input  wire logic                         q_room,
    output mmrc_pkg::qpush_t                  push
);
    import mmrc_pkg::*;

    localparam int END_W = START_W + 1;

    logic              in_valid_reg;
    logic              in_valid_next;
    desc_t             in_desc_reg;
    logic              in_last_reg;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    desc_t             pend_reg;
    desc_t             pend_next;
    logic              consume;
    logic [END_W-1:0]  pend_end;
    logic [PAGES_W:0]  page_sum;
    logic              merge;

    assign consume  = in_valid_reg & q_room;
    assign s_tready = ~in_valid_reg | consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    // End address of the pending run, kept one bit wider so it never wraps.
    assign pend_end = {1'b0, pend_reg.start}
                    + {1'b0, pend_reg.pages, {PAGE_SHIFT{1'b0}}};
    assign page_sum = {1'b0, pend_reg.pages} + {1'b0, in_desc_reg.pages};

    assign merge = pend_valid_reg
                 && in_desc_reg.attr == pend_reg.attr
                 && pend_end == {1'b0, in_desc_reg.start}
                 && type_mask[in_desc_reg.dtype]
                 && type_mask[pend_reg.dtype];

    always_comb begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        push            = '0;
        if (consume) begin
            if (merge) begin
                pend_next.pages = page_sum[PAGES_W] ? PAGES_MAX : page_sum[PAGES_W-1:0];
            end else begin
                pend_next = in_desc_reg;
            end
            pend_valid_next = ~in_last_reg;

            // Emit the old run when the new one does not extend it, and the run on a last descriptor.
            push.a_valid = (~merge & pend_valid_reg) | in_last_reg;
            push.b_valid = ~merge & pend_valid_reg & in_last_reg;
            if (~merge & pend_valid_reg) begin
                push.a.desc = pend_reg;
                push.a.last = 1'b0;
            end else begin
                push.a.desc = pend_next;
                push.a.last = 1'b1;
            end
            push.b.desc = pend_next;
            push.b.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_desc_reg <= desc_t'(s_tdata);
            in_last_reg <= s_tlast;
        end
        pend_reg <= pend_next;
    end

    `MMRC_ASSERT_NEXT(a_last_empties, aclk, aresetn, consume && in_last_reg, !pend_valid_reg, "pending run survived a last descriptor")
    `MMRC_ASSERT_SAME(a_last_pushes, aclk, aresetn, consume && in_last_reg, push.a_valid && (push.b_valid ? push.b.last : push.a.last), "last descriptor not flushed with last flag")

endmodule

`default_nettype wire

// ===== sv/mmrc_outq.sv =====
// Result queue taking up to two words per cycle and giving one per cycle while m_tready is high.
`default_nettype none

`include "memory_map_run_coalescer_macros.svh"

module mmrc_outq #(
    parameter int DEPTH = 4
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire mmrc_pkg::qpush_t             push,
    output logic                              q_room,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [mmrc_pkg::DESC_W-1:0]  m_tdata,
    output logic                              m_tlast
);
    import mmrc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(DEPTH);

    entry_t          mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   wr_ptr_inc;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            pop;
    logic [1:0]      push_n;
    entry_t          head;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    assign pop    = m_tvalid & m_tready;
    assign push_n = {1'b0, push.a_valid} + {1'b0, push.b_valid};
    // Two free slots after this cycle's pop.
    assign q_room = ((CW + 1)'(count_reg) + (CW + 1)'(2)) <= (DEPTH_W + (CW + 1)'(pop));

    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push.b_valid) begin
            wr_ptr_next = ptr_inc(wr_ptr_inc);
        end else if (push.a_valid) begin
            wr_ptr_next = wr_ptr_inc;
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.a_valid) begin
            mem[wr_ptr_reg] <= push.a;
        end
        if (push.b_valid) begin
            mem[wr_ptr_inc] <= push.b;
        end
    end

    assign head     = mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.desc;
    assign m_tlast  = head.last;

    `MMRC_ASSERT_SAME(a_no_overflow, aclk, aresetn, 1'b1, (CW + 1)'(count_reg) <= DEPTH_W, "result queue overflow")
    `MMRC_ASSERT_SAME(a_slot_order, aclk, aresetn, push.b_valid, push.a_valid, "second slot pushed without first")

endmodule

`default_nettype wire

// ===== sv/memory_map_run_coalescer.sv =====
// Top level of the memory map run coalescer.
//
//  channel   dir  handshake                 payload
//  s_        in   s_tvalid / s_tready       s_tdata descriptor, s_tlast end of map
//  m_        out  m_tvalid / m_tready       m_tdata descriptor, m_tlast end of map
//  apb       in   psel+penable, pready=1    mergeable type mask at address 0
//
// One descriptor word is accepted per cycle unless s_tready drops; it waits
// in the input register, where the end-address add, the compares and the
// saturating page add decide between merge and emit against the single
// pending run. A word yields zero, one or two result words; the result queue
// (QUEUE_DEPTH entries) takes both in the same cycle and drains one per
// cycle while m_tready is high, so a merged or plain stream runs at one word
// per cycle without stalls; only a flushed last descriptor yields two words.
// s_tready drops only when the input register holds a word and the queue
// lacks two free slots. Reset (aresetn low, synchronous) empties the queue,
// drops the pending run and sets the mask to types 3 and 4.
`default_nettype none

module memory_map_run_coalescer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // s_tdata: desc_type[3:0], phys_start[55:4], page_count[95:56],
    //          attr_mask[159:96]
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [mmrc_pkg::DESC_W-1:0]      s_tdata,
    input  wire logic                             s_tlast,
    // m_tdata: out_type[3:0], out_start[55:4], out_pages[95:56],
    //          out_attr[159:96]
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [mmrc_pkg::DESC_W-1:0]      m_tdata,
    output logic                                  m_tlast,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mmrc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [mmrc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [mmrc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import mmrc_pkg::*;

    logic [MASK_W-1:0] type_mask;
    logic              q_room;
    qpush_t            push;

    // Register file: mask of type codes allowed to coalesce.
    mmrc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .type_mask (type_mask)
    );

    // Hold the incoming word, decide merge or emit, advance the pending run.
    mmrc_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .type_mask (type_mask),
        .q_room    (q_room),
        .push      (push)
    );

    // Buffer emitted runs so the input keeps moving while m_ stalls.
    mmrc_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .q_room   (q_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
